/* rtl/core/gjpc_pkg.sv */
// ----------------------------------------------------------------------------
// gjpc_pkg: shared types and constants of the grid jump path cover matcher
// Holds the configuration register indexes, field widths and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gjpc_pkg;

   // fixed field widths
   localparam int COUNT_W = 13;   // cover_count and the cell counters
   localparam int CFG_W   = 7;    // widest configuration register
   localparam int DIM_W   = 7;    // row_count / col_count
   localparam int JUMP_W  = 6;    // jump_a / jump_b
   localparam int IDX_W   = 2;    // configuration register index

   // configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_ROW_COUNT = 2'd0,
      REG_COL_COUNT = 2'd1,
      REG_JUMP_A    = 2'd2,
      REG_JUMP_B    = 2'd3
   } reg_index_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;         // store one accepted cell
      logic solve_init;   // reset sweep, start and match counters
      logic clr;          // clear one entry of owner and visited maps
      logic start_init;   // take the next start cell as search root
      logic k_inc;        // advance to the next move
      logic probe_rd;     // read maps at the current target
      logic claim;        // mark the target visited
      logic own_wr;       // give the free target to the current cell
      logic push;         // save the frame and descend into the owner
      logic stk_rd;       // read the frame below the top
      logic aug_wr;       // flip the saved frame's edge into the matching
      logic pop_wr;       // resume the saved frame with its next move
      logic match_inc;    // one more matched pair
      logic next_start;   // step to the next start cell
      logic emit;         // load the result register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic last_cell;
      logic clr_last;
      logic start_blocked;
      logic k_done;
      logic tgt_off;
      logic tgt_taken;
      logic owner_free;
      logic depth_zero;
      logic depth_one;
      logic last_start;
      logic rsp_free;
   } status_type;

endpackage

/* rtl/core/gjpc_if.sv */
// ----------------------------------------------------------------------------
// gjpc channel interfaces
// Valid/ready channels for grid cells in and the cover count out.
// ----------------------------------------------------------------------------
interface gjpc_req_if;
   logic valid;
   logic ready;
   logic cell_blocked;

   modport source (output valid, output cell_blocked, input ready);
   modport sink   (input valid, input cell_blocked, output ready);
endinterface

interface gjpc_rsp_if import gjpc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] cover_count;

   modport source (output valid, output cover_count, input ready);
   modport sink   (input valid, input cover_count, output ready);
endinterface

/* rtl/core/gjpc_ram.sv */
// ----------------------------------------------------------------------------
// gjpc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gjpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/gjpc_datapath.sv */
// ----------------------------------------------------------------------------
// gjpc_datapath: grid storage, matching maps, search stack and counters
// Executes the controller's commands one per cycle and reports status.
// ----------------------------------------------------------------------------
module gjpc_datapath import gjpc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         st,
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  logic               cell_blocked,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COUNT_W-1:0] cover_count
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CLW;
   localparam int DEPTH = 1 << AW;
   localparam int EW    = AW + 1;
   localparam int OW    = AW + 1;
   localparam int SW    = 2 * AW + 2;

   // configuration
   logic [DIM_W-1:0]  rows_cfg_ff, cols_cfg_ff;
   logic [JUMP_W-1:0] ja_ff, jb_ff;
   logic [DIM_W-1:0]  rows_eff, cols_eff;
   logic [7:0]        rows8_m1, cols8_m1;

   // loading
   logic [RW-1:0]      ld_row_ff, ld_row_in;
   logic [CLW-1:0]     ld_col_ff, ld_col_in;
   logic [COUNT_W-1:0] free_ff, free_in;

   // solve control
   logic [AW-1:0]      clr_ff;
   logic [RW-1:0]      st_row_ff;
   logic [CLW-1:0]     st_col_ff;
   logic [EW-1:0]      epoch_ff;
   logic [COUNT_W-1:0] matched_ff;
   logic [AW-1:0]      u_ff, v_ff;
   logic [2:0]         k_ff;
   logic [AW:0]        depth_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] cover_ff;

   // target computation
   logic [JUMP_W-1:0] dr, dc;
   logic [7:0]        nr8, nc8;
   logic              under;
   logic [AW-1:0]     tgt;

   // memory ports
   logic          blk_we, blk_rd;
   logic [AW-1:0] blk_waddr, blk_raddr;
   logic          vis_we;
   logic [AW-1:0] vis_waddr;
   logic [EW-1:0] vis_wdata, vis_rd;
   logic          own_we;
   logic [AW-1:0] own_waddr;
   logic [OW-1:0] own_wdata, own_rd;
   logic [AW-1:0] stk_raddr;
   logic [SW-1:0] stk_wdata, stk_rd;
   logic [AW-1:0] stk_u, stk_v;
   logic [1:0]    stk_k;

   // clamp grid dimensions to the supported range
   always_comb begin
      if (rows_cfg_ff == '0) rows_eff = DIM_W'(1);
      else if (rows_cfg_ff > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
      else rows_eff = rows_cfg_ff;
      if (cols_cfg_ff == '0) cols_eff = DIM_W'(1);
      else if (cols_cfg_ff > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
      else cols_eff = cols_cfg_ff;
      rows8_m1 = 8'(rows_eff) - 8'd1;
      cols8_m1 = 8'(cols_eff) - 8'd1;
   end

   // jump target of move k from cell u
   always_comb begin
      dr    = k_ff[1] ? jb_ff : ja_ff;
      dc    = k_ff[1] ? ja_ff : jb_ff;
      nr8   = 8'(u_ff[AW-1:CLW]) + 8'(dr);
      under = k_ff[0] && (8'(u_ff[CLW-1:0]) < 8'(dc));
      nc8   = k_ff[0] ? 8'(u_ff[CLW-1:0]) - 8'(dc) : 8'(u_ff[CLW-1:0]) + 8'(dc);
      tgt   = {nr8[RW-1:0], nc8[CLW-1:0]};
   end

   assign {stk_u, stk_k, stk_v} = stk_rd;

   // load position and free count
   always_comb begin
      ld_row_in = ld_row_ff;
      ld_col_in = ld_col_ff;
      if (st.last_cell) begin
         ld_row_in = '0;
         ld_col_in = '0;
      end else if (8'(ld_col_ff) == cols8_m1) begin
         ld_col_in = '0;
         ld_row_in = ld_row_ff + RW'(1);
      end else begin
         ld_col_in = ld_col_ff + CLW'(1);
      end
      free_in = ((ld_row_ff == '0 && ld_col_ff == '0) ? '0 : free_ff)
              + COUNT_W'(!cell_blocked);
   end

   // memory port selection
   always_comb begin
      blk_we    = cmd.load;
      blk_waddr = {ld_row_ff, ld_col_ff};
      blk_raddr = cmd.start_init ? {st_row_ff, st_col_ff} : tgt;

      vis_we    = cmd.clr | cmd.claim;
      vis_waddr = cmd.clr ? clr_ff : v_ff;
      vis_wdata = cmd.clr ? '0 : epoch_ff;

      own_we    = cmd.clr | cmd.own_wr | cmd.aug_wr;
      own_waddr = cmd.clr ? clr_ff : (cmd.aug_wr ? stk_v : v_ff);
      own_wdata = cmd.clr ? '0 : (cmd.aug_wr ? {1'b1, stk_u} : {1'b1, u_ff});

      stk_raddr = AW'(depth_ff - (AW+1)'(1));
      stk_wdata = {u_ff, k_ff[1:0], v_ff};
   end

   gjpc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_blocked (
      .clock, .wr_en(blk_we), .wr_addr(blk_waddr), .wr_data(cell_blocked),
      .rd_addr(blk_raddr), .rd_data(blk_rd)
   );

   gjpc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_visited (
      .clock, .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(tgt), .rd_data(vis_rd)
   );

   gjpc_ram #(.WIDTH(OW), .DEPTH(DEPTH)) u_owner (
      .clock, .wr_en(own_we), .wr_addr(own_waddr), .wr_data(own_wdata),
      .rd_addr(tgt), .rd_data(own_rd)
   );

   gjpc_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack (
      .clock, .wr_en(cmd.push), .wr_addr(depth_ff[AW-1:0]), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rd)
   );

   // status
   always_comb begin
      st.last_cell     = (8'(ld_row_ff) == rows8_m1) && (8'(ld_col_ff) == cols8_m1);
      st.clr_last      = &clr_ff;
      st.start_blocked = blk_rd;
      st.k_done        = k_ff[2];
      st.tgt_off       = under || (nr8 > rows8_m1) || (nc8 > cols8_m1);
      st.tgt_taken     = blk_rd || (vis_rd == epoch_ff);
      st.owner_free    = !own_rd[OW-1];
      st.depth_zero    = (depth_ff == '0);
      st.depth_one     = (depth_ff == (AW+1)'(1));
      st.last_start    = (8'(st_row_ff) == rows8_m1) && (8'(st_col_ff) == cols8_m1);
      st.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   // configuration and load counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= DIM_W'(1);
         cols_cfg_ff <= DIM_W'(1);
         ja_ff       <= JUMP_W'(1);
         jb_ff       <= JUMP_W'(2);
         ld_row_ff   <= '0;
         ld_col_ff   <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_ROW_COUNT: rows_cfg_ff <= csr_wdata[DIM_W-1:0];
            REG_COL_COUNT: cols_cfg_ff <= csr_wdata[DIM_W-1:0];
            REG_JUMP_A:    ja_ff       <= csr_wdata[JUMP_W-1:0];
            REG_JUMP_B:    jb_ff       <= csr_wdata[JUMP_W-1:0];
            default:       ;
         endcase
         ld_row_ff <= '0;
         ld_col_ff <= '0;
      end else if (cmd.load) begin
         ld_row_ff <= ld_row_in;
         ld_col_ff <= ld_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) free_ff <= free_in;
   end

   // search registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         k_ff         <= '0;
      end else begin
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (cmd.start_init) begin
            depth_ff <= '0;
            k_ff     <= '0;
         end else if (cmd.push) begin
            depth_ff <= depth_ff + (AW+1)'(1);
            k_ff     <= '0;
         end else if (cmd.pop_wr) begin
            depth_ff <= depth_ff - (AW+1)'(1);
            k_ff     <= {1'b0, stk_k} + 3'd1;
         end else if (cmd.aug_wr) begin
            depth_ff <= depth_ff - (AW+1)'(1);
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.solve_init) begin
         clr_ff     <= '0;
         st_row_ff  <= '0;
         st_col_ff  <= '0;
         epoch_ff   <= EW'(1);
         matched_ff <= '0;
      end else begin
         if (cmd.clr) clr_ff <= clr_ff + AW'(1);
         if (cmd.match_inc) matched_ff <= matched_ff + COUNT_W'(1);
         if (cmd.next_start) begin
            epoch_ff <= epoch_ff + EW'(1);
            if (8'(st_col_ff) == cols8_m1) begin
               st_col_ff <= '0;
               st_row_ff <= st_row_ff + RW'(1);
            end else begin
               st_col_ff <= st_col_ff + CLW'(1);
            end
         end
      end
      if (cmd.start_init) u_ff <= {st_row_ff, st_col_ff};
      else if (cmd.push) u_ff <= own_rd[AW-1:0];
      else if (cmd.pop_wr) u_ff <= stk_u;
      if (cmd.probe_rd) v_ff <= tgt;
      if (cmd.emit) cover_ff <= free_ff - matched_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cover_count = cover_ff;

endmodule

/* rtl/core/gjpc_ctrl.sv */
// ----------------------------------------------------------------------------
// gjpc_ctrl: sequencer of loading, map clearing and the augmenting search
// Walks the explicit-stack search one step per cycle and issues commands.
// ----------------------------------------------------------------------------
module gjpc_ctrl import gjpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_CLEAR, S_START, S_SCHK, S_PROBE, S_EVAL,
      S_AUGRD, S_AUGWR, S_POPRD, S_POPWR, S_NEXT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (st.last_cell) begin
                  cmd.solve_init = 1'b1;
                  state_in       = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_last) state_in = S_START;
         end
         S_START: begin
            cmd.start_init = 1'b1;
            state_in       = S_SCHK;
         end
         S_SCHK: begin
            state_in = st.start_blocked ? S_NEXT : S_PROBE;
         end
         S_PROBE: begin
            if (st.k_done) state_in = S_POPRD;
            else if (st.tgt_off) cmd.k_inc = 1'b1;
            else begin
               cmd.probe_rd = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            if (st.tgt_taken) begin
               cmd.k_inc = 1'b1;
               state_in  = S_PROBE;
            end else begin
               cmd.claim = 1'b1;
               if (st.owner_free) begin
                  cmd.own_wr = 1'b1;
                  if (st.depth_zero) begin
                     cmd.match_inc = 1'b1;
                     state_in      = S_NEXT;
                  end else begin
                     state_in = S_AUGRD;
                  end
               end else begin
                  cmd.push = 1'b1;
                  state_in = S_PROBE;
               end
            end
         end
         S_AUGRD: begin
            cmd.stk_rd = 1'b1;
            state_in   = S_AUGWR;
         end
         S_AUGWR: begin
            cmd.aug_wr = 1'b1;
            if (st.depth_one) begin
               cmd.match_inc = 1'b1;
               state_in      = S_NEXT;
            end else begin
               state_in = S_AUGRD;
            end
         end
         S_POPRD: begin
            if (st.depth_zero) state_in = S_NEXT;
            else begin
               cmd.stk_rd = 1'b1;
               state_in   = S_POPWR;
            end
         end
         S_POPWR: begin
            cmd.pop_wr = 1'b1;
            state_in   = S_PROBE;
         end
         S_NEXT: begin
            if (st.last_start) state_in = S_DONE;
            else begin
               cmd.next_start = 1'b1;
               state_in       = S_START;
            end
         end
         S_DONE: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else state_ff <= state_in;
   end

endmodule

/* rtl/core/grid_jump_path_cover_matcher_top.sv */
// ----------------------------------------------------------------------------
// grid_jump_path_cover_matcher_top: minimum jump path cover of a grid
// Loads a grid of free/blocked cells and returns the minimum path cover.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle, while the block is loading, in row-major
// order. After the last cell of the configured grid the block stops taking
// cells, clears all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries of its
// owner and visited maps (4096 at the default size), then runs one
// augmenting search from every free cell. Each search step (move probe, map
// read, stack push or pop, or one augmenting edge flip) goes through
// single-port reads of the map and stack RAMs, so the solve time grows with
// the number of edges visited, roughly cells times searched edges in the
// worst case. One result is sent per grid; the next grid may load while
// that result waits. A configuration write discards any partly loaded grid.
module grid_jump_path_cover_matcher_top import gjpc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   gjpc_req_if.sink         req_chan,
   gjpc_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type st;

   gjpc_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st,
      .cmd
   );

   gjpc_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
      .clock,
      .reset,
      .cmd,
      .st,
      .csr_we,
      .csr_index,
      .csr_wdata,
      .cell_blocked (req_chan.cell_blocked),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .cover_count  (rsp_chan.cover_count)
   );

`ifndef SYNTHESIS
   // the result register is only loaded once the previous result has gone
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten before transfer");

   // a loaded result is offered in the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_chan.valid)
      else $error("result not offered after emit");

   // no cell is taken while the matching maps are swept
   a_clear_no_load: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !req_chan.ready)
      else $error("cell accepted during map clear");

   // a stack push never shares a cycle with an augmenting flip or a pop
   a_push_vs_aug: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && (cmd.aug_wr || cmd.pop_wr)))
      else $error("conflicting stack operations");
`endif

endmodule
